@@ design/srm_pkg.sv @@
// package for the sparse row add merge unit
// holds capacity, opcodes and the saturating add; no dependencies
`default_nettype none
package srm_pkg;
  localparam int MaxRowEntries = 16;
  localparam int RowCap = (MaxRowEntries > 32) ? 32 : ((MaxRowEntries < 1) ? 1 : MaxRowEntries);
  localparam int AddrW = 5;
  localparam int CntW = 6;
  localparam logic [CntW-1:0] RowCapC = CntW'(RowCap);

  localparam logic [1:0] OpFirst = 2'd0;
  localparam logic [1:0] OpSecond = 2'd1;
  localparam logic [1:0] OpEnd = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else sat_add = s[31:0];
  endfunction
endpackage
`default_nettype wire

@@ design/sparse_row_add_merge_unit.sv @@
// top level of the sparse row add merge unit
// arrival store and sorted store in synchronous memories; uses srm_pkg
//
//  channel | dir | tdata fields (low bit up)            | tuser / tlast
//  in_     | in  | column[31:0], entry_value[63:32]     | tuser opcode[1:0]
//  out_    | out | out_column, out_value, row_pointer   | tuser is_entry,overflow; tlast last
//
// an entry is accepted, then compared with the sorted entries in turn (read, then compare);
// larger entries are shifted up one place each (read, then write) before the final write
// end of row emits the items of the selected store one at a time, read port bound
// reset clears counts and flags; the stores need no clearing
// out_tvalid holds until taken; the input stalls while a row is being emitted
`default_nettype none
module sparse_row_add_merge_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // column, entry_value
  input  wire logic [1:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // out_column, out_value, row_pointer
  output logic [1:0]       out_tuser,  // is_entry, overflow
  output logic             out_tlast   // last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_FCHK = 3'd2;
  localparam logic [2:0] S_SHFT = 3'd3;
  localparam logic [2:0] S_SWR  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EOUT = 3'd6;

  logic [31:0] a_col_m [32];
  logic [31:0] a_val_m [32];
  logic [31:0] s_col_m [32];
  logic [31:0] s_val_m [32];

  logic [2:0] state_r, state_nxt;
  logic [srm_pkg::CntW-1:0] a_cnt_r, a_cnt_nxt, s_cnt_r, s_cnt_nxt;
  logic [srm_pkg::CntW-1:0] pos_r, pos_nxt;
  logic seen1_r, seen1_nxt, seen2_r, seen2_nxt, drop_r, drop_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] col_r, col_nxt, val_r, val_nxt;
  logic sec_r, sec_nxt, both_r, both_nxt;
  logic ov_r, ov_nxt;
  logic [srm_pkg::CntW-1:0] n_r, n_nxt;

  logic s_we, a_we;
  logic [srm_pkg::AddrW-1:0] s_waddr, s_raddr, a_raddr;
  logic [31:0] s_wcol, s_wval;
  logic [31:0] s_rcol_r, s_rval_r, a_rcol_r, a_rval_r;

  logic ovalid_r, ovalid_nxt;
  logic [95:0] odata_r, odata_nxt;
  logic [1:0] ouser_r, ouser_nxt;
  logic olast_r, olast_nxt;

  logic in_acc, out_free;
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
  assign out_tlast = olast_r;

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_col_m[s_waddr] <= s_wcol;
      s_val_m[s_waddr] <= s_wval;
    end
    if (a_we) begin
      a_col_m[a_cnt_r[srm_pkg::AddrW-1:0]] <= in_tdata[31:0];
      a_val_m[a_cnt_r[srm_pkg::AddrW-1:0]] <= in_tdata[63:32];
    end
    s_rcol_r <= s_col_m[s_raddr];
    s_rval_r <= s_val_m[s_raddr];
    a_rcol_r <= a_col_m[a_raddr];
    a_rval_r <= a_val_m[a_raddr];
  end

  always_comb begin
    state_nxt = state_r; a_cnt_nxt = a_cnt_r; s_cnt_nxt = s_cnt_r; pos_nxt = pos_r;
    seen1_nxt = seen1_r; seen2_nxt = seen2_r; drop_nxt = drop_r; total_nxt = total_r;
    col_nxt = col_r; val_nxt = val_r; sec_nxt = sec_r; both_nxt = both_r; ov_nxt = ov_r;
    n_nxt = n_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt = odata_r; ouser_nxt = ouser_r; olast_nxt = olast_r;
    s_we = 1'b0; a_we = 1'b0;
    s_waddr = pos_r[srm_pkg::AddrW-1:0];
    s_wcol = col_r; s_wval = val_r;
    s_raddr = pos_r[srm_pkg::AddrW-1:0];
    a_raddr = pos_r[srm_pkg::AddrW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          col_nxt = in_tdata[31:0];
          val_nxt = in_tdata[63:32];
          sec_nxt = (in_tuser == srm_pkg::OpSecond);
          pos_nxt = '0;
          if (in_tuser == srm_pkg::OpFirst || in_tuser == srm_pkg::OpSecond) begin
            if (in_tuser == srm_pkg::OpFirst) seen1_nxt = 1'b1;
            else seen2_nxt = 1'b1;
            if (a_cnt_r < srm_pkg::RowCapC) begin
              a_we = 1'b1;
              a_cnt_nxt = a_cnt_r + 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
            state_nxt = S_FIND;
          end else if (in_tuser == srm_pkg::OpEnd) begin
            both_nxt = seen1_r && seen2_r;
            ov_nxt = drop_r;
            n_nxt = (seen1_r && seen2_r) ? s_cnt_r : a_cnt_r;
            if (!seen1_r && !seen2_r) begin
              state_nxt = S_EOUT;
              n_nxt = '0;
            end else begin
              total_nxt = total_r + 32'((seen1_r && seen2_r) ? s_cnt_r : a_cnt_r);
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_FIND: begin
        if (pos_r >= s_cnt_r) begin
          if (s_cnt_r >= srm_pkg::RowCapC) begin
            drop_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            s_we = 1'b1;
            s_cnt_nxt = s_cnt_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (s_rcol_r < col_r) begin
          pos_nxt = pos_r + 1'b1;
          state_nxt = S_FIND;
        end else if (s_rcol_r == col_r) begin
          s_we = 1'b1;
          s_wval = sec_r ? srm_pkg::sat_add(s_rval_r, val_r) : val_r;
          state_nxt = S_IDLE;
        end else if (s_cnt_r >= srm_pkg::RowCapC) begin
          drop_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // shift from the top down to pos; n_r walks the destination index
          n_nxt = s_cnt_r;
          state_nxt = S_SHFT;
        end
      end
      S_SHFT: begin
        if (n_r == pos_r) begin
          s_we = 1'b1;
          s_cnt_nxt = s_cnt_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          s_raddr = srm_pkg::AddrW'(n_r - 1'b1);
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        s_we = 1'b1;
        s_waddr = n_r[srm_pkg::AddrW-1:0];
        s_wcol = s_rcol_r; s_wval = s_rval_r;
        n_nxt = n_r - 1'b1;
        state_nxt = S_SHFT;
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          if (n_r == '0) begin
            odata_nxt = {total_r, 64'd0};
            ouser_nxt = 2'b00;
            olast_nxt = 1'b1;
          end else begin
            odata_nxt = both_r ? {total_r, s_rval_r, s_rcol_r} : {total_r, a_rval_r, a_rcol_r};
            ouser_nxt = {ov_r, 1'b1};
            olast_nxt = (pos_r + 1'b1 == n_r);
          end
          if (n_r == '0 || pos_r + 1'b1 == n_r) begin
            a_cnt_nxt = '0; s_cnt_nxt = '0; seen1_nxt = 1'b0; seen2_nxt = 1'b0;
            drop_nxt = 1'b0; state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; a_cnt_r <= '0; s_cnt_r <= '0; seen1_r <= 1'b0; seen2_r <= 1'b0;
      drop_r <= 1'b0; total_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; a_cnt_r <= a_cnt_nxt; s_cnt_r <= s_cnt_nxt;
      seen1_r <= seen1_nxt; seen2_r <= seen2_nxt; drop_r <= drop_nxt;
      total_r <= total_nxt; ovalid_r <= ovalid_nxt;
    end
    pos_r <= pos_nxt; col_r <= col_nxt; val_r <= val_nxt; sec_r <= sec_nxt;
    both_r <= both_nxt; ov_r <= ov_nxt; n_r <= n_nxt;
    odata_r <= odata_nxt; ouser_r <= ouser_nxt; olast_r <= olast_nxt;
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    a_cnt_r <= srm_pkg::RowCapC) else $error("arrival count past capacity");
  s_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    s_cnt_r <= srm_pkg::RowCapC) else $error("sorted count past capacity");
  last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EOUT && out_free && olast_nxt) |=> (a_cnt_r == '0 && s_cnt_r == '0))
    else $error("row state not cleared after last item");
  marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ouser_r[0]) |-> (olast_r && !ouser_r[1]))
    else $error("empty row marker malformed");
endmodule
`default_nettype wire

@@ tb/sparse_row_add_merge_checker.sv @@
// checker for the sparse row add merge unit: watches the input and output channels,
// predicts the merged row entries and compares them item by item; uses srm_pkg
`timescale 1ns / 1ps
`default_nettype none
module sparse_row_add_merge_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_count
);
  typedef struct packed {
    logic [31:0] column;
    logic [31:0] value;
    logic        is_entry;
    logic        last;
    logic [31:0] row_pointer;
    logic        overflow;
  } merged_entry_t;

  merged_entry_t expected_entries[$];
  logic [31:0] arr_col[32], arr_val[32], srt_col[32], srt_val[32];
  int arr_n, srt_n;
  bit got_first, got_second, dropped;
  logic [31:0] row_ptr;
  int mismatches;

  assign fail_count = mismatches;
  assign pending_count = expected_entries.size();

  function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sh7fffffff) s = 64'sh7fffffff;
    if (s < -64'sh80000000) s = -64'sh80000000;
    return s[31:0];
  endfunction

  task automatic add_expected(merged_entry_t e);
    expected_entries.insert(expected_entries.size(), e);
  endtask

  task automatic sorted_insert(bit second, logic [31:0] col, logic [31:0] val);
    int pos;
    pos = 0;
    while (pos < srt_n && srt_col[pos] < col) pos++;
    if (pos < srt_n && srt_col[pos] == col) begin
      srt_val[pos] = second ? clamp_add(srt_val[pos], val) : val;
      return;
    end
    if (srt_n >= srm_pkg::RowCap) begin
      dropped = 1;
      return;
    end
    for (int i = srt_n; i > pos; i--) begin
      srt_col[i] = srt_col[i-1];
      srt_val[i] = srt_val[i-1];
    end
    srt_col[pos] = col;
    srt_val[pos] = val;
    srt_n++;
  endtask

  task automatic merge_item(logic [1:0] op, logic [31:0] col, logic [31:0] val);
    merged_entry_t e;
    int n;
    bit both;
    if (op == srm_pkg::OpFirst || op == srm_pkg::OpSecond) begin
      if (op == srm_pkg::OpFirst) got_first = 1;
      else got_second = 1;
      if (arr_n < srm_pkg::RowCap) begin
        arr_col[arr_n] = col;
        arr_val[arr_n] = val;
        arr_n++;
      end else begin
        dropped = 1;
      end
      sorted_insert(op == srm_pkg::OpSecond, col, val);
    end else if (op == srm_pkg::OpEnd) begin
      if (!got_first && !got_second) begin
        e = '{32'd0, 32'd0, 1'b0, 1'b1, row_ptr, 1'b0};
        add_expected(e);
      end else begin
        both = got_first && got_second;
        n = both ? srt_n : arr_n;
        row_ptr = row_ptr + n;
        for (int k = 0; k < n; k++) begin
          e.column = both ? srt_col[k] : arr_col[k];
          e.value = both ? srt_val[k] : arr_val[k];
          e.is_entry = 1;
          e.last = (k + 1 == n);
          e.row_pointer = row_ptr;
          e.overflow = dropped;
          add_expected(e);
        end
      end
      arr_n = 0;
      srt_n = 0;
      got_first = 0;
      got_second = 0;
      dropped = 0;
    end
  endtask

  always @(posedge clk) begin
    merged_entry_t got, exp_e;
    if (!rst_n) begin
      arr_n = 0;
      srt_n = 0;
      got_first = 0;
      got_second = 0;
      dropped = 0;
      row_ptr = 0;
      mismatches = 0;
      expected_entries.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[31:0], out_tdata[63:32], out_tuser[0], out_tlast,
                out_tdata[95:64], out_tuser[1]};
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item col=%h val=%h", got.column, got.value);
        end else begin
          exp_e = expected_entries.pop_front();
          if (got !== exp_e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch exp col=%h val=%h ent=%b last=%b ptr=%h ovf=%b",
                        " / got col=%h val=%h ent=%b last=%b ptr=%h ovf=%b"},
                       exp_e.column, exp_e.value, exp_e.is_entry, exp_e.last,
                       exp_e.row_pointer, exp_e.overflow, got.column, got.value,
                       got.is_entry, got.last, got.row_pointer, got.overflow);
          end
        end
      end
      if (in_tvalid && in_tready) merge_item(in_tuser, in_tdata[31:0], in_tdata[63:32]);
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench top for the sparse row add merge unit: drives rows of entries
// with random gaps and stalls; checking lives in sparse_row_add_merge_checker
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tlast;
  logic out_tready = 1'b0;
  logic [63:0] in_tdata;
  logic [1:0] in_tuser, out_tuser;
  logic [95:0] out_tdata;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit no_idle;

  sparse_row_add_merge_unit u_top (.*);
  sparse_row_add_merge_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** sparse_row_add_merge_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= no_idle || ($urandom_range(99) >= 18);

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(logic [1:0] op, logic [31:0] col, logic [31:0] val);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {val, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_row();
    int len, mode, ncols;
    logic [1:0] op;
    logic [31:0] col;
    logic [31:0] base;
    len = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(6);
    mode = $urandom_range(3);
    ncols = $urandom_range(1, 8);
    base = ($urandom_range(3) == 0) ? $urandom : 32'hffffffff - $urandom_range(20);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: op = srm_pkg::OpFirst;
        1: op = srm_pkg::OpSecond;
        default: op = $urandom_range(1) ? srm_pkg::OpSecond : srm_pkg::OpFirst;
      endcase
      col = ($urandom_range(7) == 0) ? $urandom : base + $urandom_range(ncols);
      send_item(op, col, pick_value());
      if ($urandom_range(29) == 0) send_item(srm_pkg::OpUnused, $urandom, $urandom);
    end
    send_item(srm_pkg::OpEnd, $urandom, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    no_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty row, first only with duplicates, second only
    send_item(srm_pkg::OpEnd, 32'hffffffff, 32'hffffffff);
    send_item(srm_pkg::OpFirst, 32'd5, 32'h00010000);
    send_item(srm_pkg::OpFirst, 32'd5, 32'h00020000);
    send_item(srm_pkg::OpFirst, 32'hffffffff, 32'h7fffffff);
    send_item(srm_pkg::OpEnd, 32'd0, 32'd0);
    send_item(srm_pkg::OpSecond, 32'd0, 32'h80000000);
    send_item(srm_pkg::OpEnd, 32'd0, 32'd0);
    // both matrices: saturation both ways, last wins after a second entry
    send_item(srm_pkg::OpFirst, 32'd9, 32'h7fffffff);
    send_item(srm_pkg::OpSecond, 32'd9, 32'h7fffffff);
    send_item(srm_pkg::OpFirst, 32'd2, 32'h80000000);
    send_item(srm_pkg::OpSecond, 32'd2, 32'h80000000);
    send_item(srm_pkg::OpSecond, 32'd4, 32'h00000001);
    send_item(srm_pkg::OpFirst, 32'd4, 32'hfffffffe);
    send_item(srm_pkg::OpUnused, 32'hffffffff, 32'hffffffff);
    send_item(srm_pkg::OpSecond, 32'hffffffff, 32'hffffffff);
    send_item(srm_pkg::OpEnd, 32'd0, 32'd0);
    // capacity overflow in both stores
    for (int i = 0; i < srm_pkg::RowCap + 2; i++)
      send_item(i[0] ? srm_pkg::OpSecond : srm_pkg::OpFirst, i, i);
    send_item(srm_pkg::OpEnd, 32'd0, 32'd0);
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    for (int r = 0; r < 38; r++) begin
      no_idle = (r >= 12 && r < 22);
      random_row();
    end
    no_idle = 0;
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("** sparse_row_add_merge_unit: PASSED **");
    else $display("** sparse_row_add_merge_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
